>>> rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared constants and types of the box pair overlap finder.
// ----------------------------------------------------------------------------
package aabb_pkg;

    localparam int MAX_BOXES  = 32;
    localparam int COORD_BITS = 32;
    localparam int IDX_W      = $clog2(MAX_BOXES);
    localparam int CNT_W      = $clog2(MAX_BOXES + 1);
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_MAX_Z = 3'd5;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] min_z;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] max_y;
        logic signed [COORD_BITS-1:0] max_z;
    } box_t;

    typedef struct packed {
        logic [IDX_W-1:0] low_index;
        logic [IDX_W-1:0] high_index;
        box_t             isect;
        logic             last_pair;
    } pair_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

>>> rtl/aabb_ram.sv
// ----------------------------------------------------------------------------
// aabb_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
module aabb_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/aabb_pair_overlap_finder_top.sv
// ----------------------------------------------------------------------------
// aabb_pair_overlap_finder_top
// Numbers incoming boxes, stores them while there is room, and reports every
// overlap of a stored new box with an earlier one together with the intersection box.
// ----------------------------------------------------------------------------
// A box with earlier boxes in its set is accepted, then the stored boxes are
// read from the box memory and tested one per cycle, pausing while a held hit
// waits on a stalled output, and a flush step then sends out the last pair.
// A box that finds an empty or full store is accepted without a scan.
// Reset clears the control state, the box count and the model box to zero.
// ----------------------------------------------------------------------------
module aabb_pair_overlap_finder_top (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    cfg_write,
    input  logic [aabb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [aabb_pkg::COORD_BITS-1:0]         cfg_data,

    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    first_box,
    input  logic                                    bound_ok,
    input  logic signed [aabb_pkg::COORD_BITS-1:0]  box_min_x,
    input  logic signed [aabb_pkg::COORD_BITS-1:0]  box_min_y,
    input  logic signed [aabb_pkg::COORD_BITS-1:0]  box_min_z,
    input  logic signed [aabb_pkg::COORD_BITS-1:0]  box_max_x,
    input  logic signed [aabb_pkg::COORD_BITS-1:0]  box_max_y,
    input  logic signed [aabb_pkg::COORD_BITS-1:0]  box_max_z,

    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [aabb_pkg::IDX_W-1:0]              low_index,
    output logic [aabb_pkg::IDX_W-1:0]              high_index,
    output logic signed [aabb_pkg::COORD_BITS-1:0]  isect_min_x,
    output logic signed [aabb_pkg::COORD_BITS-1:0]  isect_min_y,
    output logic signed [aabb_pkg::COORD_BITS-1:0]  isect_min_z,
    output logic signed [aabb_pkg::COORD_BITS-1:0]  isect_max_x,
    output logic signed [aabb_pkg::COORD_BITS-1:0]  isect_max_y,
    output logic signed [aabb_pkg::COORD_BITS-1:0]  isect_max_z,
    output logic                                    last_pair
);

    aabb_pkg::state_t state_reg, state_next;

    aabb_pkg::box_t                 model_reg;
    logic [aabb_pkg::CNT_W-1:0]     count_reg;
    logic [aabb_pkg::IDX_W-1:0]     idx_reg;
    logic [aabb_pkg::IDX_W-1:0]     issue_reg;
    logic [aabb_pkg::IDX_W-1:0]     rd_idx_reg;
    logic                           rd_vld_reg;
    aabb_pkg::box_t                 cur_reg;
    logic                           pend_vld_reg;
    aabb_pkg::pair_t                pend_reg;
    logic                           out_vld_reg;
    aabb_pkg::pair_t                out_reg;
    aabb_pkg::pair_t                out_next;

    logic                           accept;
    logic [aabb_pkg::CNT_W-1:0]     count_eff;
    logic                           full;
    aabb_pkg::box_t                 new_box;
    aabb_pkg::box_t                 rd_box;
    logic                           hit;
    aabb_pkg::pair_t                hit_pair;
    logic                           out_free;
    logic                           adv;
    logic                           rd_en;
    logic                           load_out;
    logic                           scan_done;

    assign accept    = in_valid && !in_stall;
    assign count_eff = first_box ? '0 : count_reg;
    assign full      = (count_eff == aabb_pkg::CNT_W'(aabb_pkg::MAX_BOXES));

    always_comb
    begin
        if (bound_ok)
        begin
            new_box.min_x = box_min_x;
            new_box.min_y = box_min_y;
            new_box.min_z = box_min_z;
            new_box.max_x = box_max_x;
            new_box.max_y = box_max_y;
            new_box.max_z = box_max_z;
        end
        else
        begin
            new_box = model_reg;
        end
    end

    aabb_ram #(
        .WIDTH ($bits(aabb_pkg::box_t)),
        .DEPTH (aabb_pkg::MAX_BOXES)
    ) u_box_ram (
        .clk   (clk),
        .we    (accept && !full),
        .waddr (count_eff[aabb_pkg::IDX_W-1:0]),
        .wdata (new_box),
        .re    (rd_en),
        .raddr (issue_reg),
        .rdata (rd_box)
    );

    // Touching boxes count as overlapping, so only strict gaps reject.
    always_comb
    begin
        hit = !(($signed(cur_reg.min_x) > $signed(rd_box.max_x)) ||
                ($signed(rd_box.min_x) > $signed(cur_reg.max_x)) ||
                ($signed(cur_reg.min_y) > $signed(rd_box.max_y)) ||
                ($signed(rd_box.min_y) > $signed(cur_reg.max_y)) ||
                ($signed(cur_reg.min_z) > $signed(rd_box.max_z)) ||
                ($signed(rd_box.min_z) > $signed(cur_reg.max_z)));

        hit_pair.low_index  = rd_idx_reg;
        hit_pair.high_index = idx_reg;
        hit_pair.last_pair  = 1'b0;
        hit_pair.isect.min_x = ($signed(cur_reg.min_x) > $signed(rd_box.min_x)) ?
                               cur_reg.min_x : rd_box.min_x;
        hit_pair.isect.min_y = ($signed(cur_reg.min_y) > $signed(rd_box.min_y)) ?
                               cur_reg.min_y : rd_box.min_y;
        hit_pair.isect.min_z = ($signed(cur_reg.min_z) > $signed(rd_box.min_z)) ?
                               cur_reg.min_z : rd_box.min_z;
        hit_pair.isect.max_x = ($signed(cur_reg.max_x) < $signed(rd_box.max_x)) ?
                               cur_reg.max_x : rd_box.max_x;
        hit_pair.isect.max_y = ($signed(cur_reg.max_y) < $signed(rd_box.max_y)) ?
                               cur_reg.max_y : rd_box.max_y;
        hit_pair.isect.max_z = ($signed(cur_reg.max_z) < $signed(rd_box.max_z)) ?
                               cur_reg.max_z : rd_box.max_z;
    end

    // A hit is held back one step so that the last one can carry the marker.
    // The scan pauses when a new hit would push out a held one into a busy output.
    assign out_free  = !out_vld_reg || !out_stall;
    assign adv       = (state_reg == aabb_pkg::ST_SCAN) &&
                       !(rd_vld_reg && hit && pend_vld_reg && !out_free);
    assign rd_en     = adv && (issue_reg != idx_reg);
    assign scan_done = adv && (issue_reg == idx_reg);
    assign load_out  = (adv && rd_vld_reg && hit && pend_vld_reg) ||
                       ((state_reg == aabb_pkg::ST_FLUSH) && pend_vld_reg && out_free);

    always_comb
    begin
        out_next           = pend_reg;
        out_next.last_pair = (state_reg == aabb_pkg::ST_FLUSH);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aabb_pkg::ST_IDLE:
            begin
                if (accept && !full && (count_eff != '0))
                begin
                    state_next = aabb_pkg::ST_SCAN;
                end
            end
            aabb_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = aabb_pkg::ST_FLUSH;
                end
            end
            aabb_pkg::ST_FLUSH:
            begin
                if (!pend_vld_reg || out_free)
                begin
                    state_next = aabb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aabb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != aabb_pkg::ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= aabb_pkg::ST_IDLE;
            model_reg    <= '0;
            count_reg    <= '0;
            issue_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    aabb_pkg::REG_MODEL_MIN_X: model_reg.min_x <= cfg_data;
                    aabb_pkg::REG_MODEL_MIN_Y: model_reg.min_y <= cfg_data;
                    aabb_pkg::REG_MODEL_MIN_Z: model_reg.min_z <= cfg_data;
                    aabb_pkg::REG_MODEL_MAX_X: model_reg.max_x <= cfg_data;
                    aabb_pkg::REG_MODEL_MAX_Y: model_reg.max_y <= cfg_data;
                    aabb_pkg::REG_MODEL_MAX_Z: model_reg.max_z <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (accept)
            begin
                count_reg  <= full ? count_eff : count_eff + aabb_pkg::CNT_W'(1);
                issue_reg  <= '0;
                rd_vld_reg <= 1'b0;
            end
            else if (adv)
            begin
                rd_vld_reg <= rd_en;
                if (rd_en)
                begin
                    issue_reg <= issue_reg + aabb_pkg::IDX_W'(1);
                end
            end

            if (adv && rd_vld_reg && hit)
            begin
                pend_vld_reg <= 1'b1;
            end
            else if ((state_reg == aabb_pkg::ST_FLUSH) && out_free)
            begin
                pend_vld_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !full)
        begin
            cur_reg <= new_box;
            idx_reg <= count_eff[aabb_pkg::IDX_W-1:0];
        end
        if (rd_en)
        begin
            rd_idx_reg <= issue_reg;
        end
        if (adv && rd_vld_reg && hit)
        begin
            pend_reg <= hit_pair;
        end
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign low_index   = out_reg.low_index;
    assign high_index  = out_reg.high_index;
    assign isect_min_x = out_reg.isect.min_x;
    assign isect_min_y = out_reg.isect.min_y;
    assign isect_min_z = out_reg.isect.min_z;
    assign isect_max_x = out_reg.isect.max_x;
    assign isect_max_y = out_reg.isect.max_y;
    assign isect_max_z = out_reg.isect.max_z;
    assign last_pair   = out_reg.last_pair;

endmodule

>>> bench/tb_aabb_pair_overlap_finder_top.sv
// ----------------------------------------------------------------------------
// tb_aabb_pair_overlap_finder_top
// Self-checking bench for the box pair overlap finder. Box requests are
// queued by phase, driven in bursts, and predicted on acceptance; each pair
// that leaves the block is compared field by field with the oldest predicted
// pair. The model box is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_aabb_pair_overlap_finder_top;

    import aabb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = MAX_BOXES + 16;
    localparam int PRINT_CAP = 100;

    typedef struct {
        logic first;
        logic bound_ok;
        box_t b;
    } box_request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [COORD_BITS-1:0] cfg_data = '0;

    logic in_valid = 1'b0;
    logic in_stall;
    logic first_box = 1'b0;
    logic bound_ok = 1'b0;
    logic signed [COORD_BITS-1:0] box_min_x = '0;
    logic signed [COORD_BITS-1:0] box_min_y = '0;
    logic signed [COORD_BITS-1:0] box_min_z = '0;
    logic signed [COORD_BITS-1:0] box_max_x = '0;
    logic signed [COORD_BITS-1:0] box_max_y = '0;
    logic signed [COORD_BITS-1:0] box_max_z = '0;

    logic out_valid;
    logic out_stall = 1'b0;
    logic [IDX_W-1:0] low_index;
    logic [IDX_W-1:0] high_index;
    logic signed [COORD_BITS-1:0] isect_min_x;
    logic signed [COORD_BITS-1:0] isect_min_y;
    logic signed [COORD_BITS-1:0] isect_min_z;
    logic signed [COORD_BITS-1:0] isect_max_x;
    logic signed [COORD_BITS-1:0] isect_max_y;
    logic signed [COORD_BITS-1:0] isect_max_z;
    logic last_pair;

    aabb_pair_overlap_finder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .first_box   (first_box),
        .bound_ok    (bound_ok),
        .box_min_x   (box_min_x),
        .box_min_y   (box_min_y),
        .box_min_z   (box_min_z),
        .box_max_x   (box_max_x),
        .box_max_y   (box_max_y),
        .box_max_z   (box_max_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .low_index   (low_index),
        .high_index  (high_index),
        .isect_min_x (isect_min_x),
        .isect_min_y (isect_min_y),
        .isect_min_z (isect_min_z),
        .isect_max_x (isect_max_x),
        .isect_max_y (isect_max_y),
        .isect_max_z (isect_max_z),
        .last_pair   (last_pair)
    );

    // Predictor state: a copy of the model box and of the box store.
    logic signed [COORD_BITS-1:0] model_reg [6];
    logic signed [COORD_BITS-1:0] kept_lo [MAX_BOXES][3];
    logic signed [COORD_BITS-1:0] kept_hi [MAX_BOXES][3];
    int kept_count = 0;

    box_request_t pending_boxes [$];
    pair_t        expected_pairs [$];

    box_request_t on_wire;
    box_request_t next_req;
    pair_t        want_pair;
    int gap_left = 0;
    int burst_left = 0;
    int stall_style = 0;
    int stall_tick = 0;
    int pairs_seen = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    initial begin
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] pair %0d: %s", $realtime, pairs_seen, what);
    endtask

    task automatic check_field(input string name, input logic [COORD_BITS-1:0] got,
                               input logic [COORD_BITS-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Appends a box request at the tail of the driver's queue.
    task automatic queue_box(input box_request_t r);
        pending_boxes.insert(pending_boxes.size(), r);
    endtask

    // Tests a new box against the stored set, queues the pairs it forms, and
    // stores it. A full store ignores the box.
    task automatic find_overlaps(input box_request_t r);
        logic signed [COORD_BITS-1:0] lo [3];
        logic signed [COORD_BITS-1:0] hi [3];
        logic signed [COORD_BITS-1:0] ilo [3];
        logic signed [COORD_BITS-1:0] ihi [3];
        pair_t found [MAX_BOXES];
        pair_t p;
        bit hit;
        int n;
        n = 0;
        if (r.first)
            kept_count = 0;
        if (kept_count >= MAX_BOXES)
            return;
        if (r.bound_ok) begin
            lo = '{r.b.min_x, r.b.min_y, r.b.min_z};
            hi = '{r.b.max_x, r.b.max_y, r.b.max_z};
        end else begin
            lo = '{model_reg[REG_MODEL_MIN_X], model_reg[REG_MODEL_MIN_Y],
                   model_reg[REG_MODEL_MIN_Z]};
            hi = '{model_reg[REG_MODEL_MAX_X], model_reg[REG_MODEL_MAX_Y],
                   model_reg[REG_MODEL_MAX_Z]};
        end
        for (int i = 0; i < kept_count; i++) begin
            hit = 1'b1;
            for (int k = 0; k < 3; k++) begin
                // Touching faces still count as an overlap.
                if (lo[k] > kept_hi[i][k] || kept_lo[i][k] > hi[k])
                    hit = 1'b0;
                ilo[k] = (lo[k] > kept_lo[i][k]) ? lo[k] : kept_lo[i][k];
                ihi[k] = (hi[k] < kept_hi[i][k]) ? hi[k] : kept_hi[i][k];
            end
            if (hit) begin
                p.low_index  = IDX_W'(i);
                p.high_index = IDX_W'(kept_count);
                p.isect      = '{ilo[0], ilo[1], ilo[2], ihi[0], ihi[1], ihi[2]};
                p.last_pair  = 1'b0;
                found[n] = p;
                n++;
            end
        end
        for (int j = 0; j < n; j++) begin
            p = found[j];
            p.last_pair = (j == n - 1);
            expected_pairs.insert(expected_pairs.size(), p);
        end
        for (int k = 0; k < 3; k++) begin
            kept_lo[kept_count][k] = lo[k];
            kept_hi[kept_count][k] = hi[k];
        end
        kept_count++;
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            first_box  <= 1'b0;
            bound_ok   <= 1'b0;
            box_min_x  <= '0;
            box_min_y  <= '0;
            box_min_z  <= '0;
            box_max_x  <= '0;
            box_max_y  <= '0;
            box_max_z  <= '0;
            gap_left   <= 0;
            burst_left <= 0;
        end else begin
            if (in_valid && !in_stall)
                find_overlaps(on_wire);
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_boxes.size() > 0) begin
                    next_req = pending_boxes.pop_front();
                    on_wire   <= next_req;
                    in_valid  <= 1'b1;
                    first_box <= next_req.first;
                    bound_ok  <= next_req.bound_ok;
                    box_min_x <= next_req.b.min_x;
                    box_min_y <= next_req.b.min_y;
                    box_min_z <= next_req.b.min_z;
                    box_max_x <= next_req.b.max_x;
                    box_max_y <= next_req.b.max_y;
                    box_max_z <= next_req.b.max_z;
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                                  : $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output stall: the style is redrawn at random from four styles, including no stall.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall   <= 1'b0;
            stall_style <= 0;
            stall_tick  <= 0;
        end else begin
            stall_tick <= stall_tick + 1;
            if (stall_tick % 128 == 0)
                stall_style <= $urandom_range(0, 3);
            case (stall_style)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 99) < 30);
                2:       out_stall <= (stall_tick % 8 >= 5);
                default: out_stall <= ($urandom_range(0, 99) < 80);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_pairs.size() == 0) begin
                report_mismatch($sformatf("unexpected pair (%0d, %0d)", low_index, high_index));
            end else begin
                want_pair = expected_pairs.pop_front();
                check_field("low_index", COORD_BITS'(low_index), COORD_BITS'(want_pair.low_index));
                check_field("high_index", COORD_BITS'(high_index),
                            COORD_BITS'(want_pair.high_index));
                check_field("isect_min_x", isect_min_x, want_pair.isect.min_x);
                check_field("isect_min_y", isect_min_y, want_pair.isect.min_y);
                check_field("isect_min_z", isect_min_z, want_pair.isect.min_z);
                check_field("isect_max_x", isect_max_x, want_pair.isect.max_x);
                check_field("isect_max_y", isect_max_y, want_pair.isect.max_y);
                check_field("isect_max_z", isect_max_z, want_pair.isect.max_z);
                check_field("last_pair", COORD_BITS'(last_pair), COORD_BITS'(want_pair.last_pair));
            end
            pairs_seen++;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic box_request_t make_box(input logic first, input logic ok,
                                              input int lx, input int ly, input int lz,
                                              input int hx, input int hy, input int hz);
        box_request_t r;
        r.first    = first;
        r.bound_ok = ok;
        r.b        = '{lx, ly, lz, hx, hy, hz};
        return r;
    endfunction

    // Clustered boxes overlap often; some are fully random or turned inside out.
    function automatic box_request_t random_box(input logic first, input int span);
        logic signed [COORD_BITS-1:0] lo [3];
        logic signed [COORD_BITS-1:0] hi [3];
        logic signed [COORD_BITS-1:0] swap;
        int c;
        int w;
        int axis;
        for (int k = 0; k < 3; k++) begin
            c = int'($urandom_range(0, 2 * span)) - span;
            w = int'($urandom_range(0, span / 2));
            lo[k] = c - w;
            hi[k] = c + w;
        end
        if ($urandom_range(0, 9) == 0) begin
            for (int k = 0; k < 3; k++) begin
                lo[k] = $urandom;
                hi[k] = $urandom;
            end
        end
        if ($urandom_range(0, 19) == 0) begin
            axis = $urandom_range(0, 2);
            swap = lo[axis];
            lo[axis] = hi[axis];
            hi[axis] = swap;
        end
        return make_box(first, ($urandom_range(0, 99) >= 12),
                        lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    task automatic write_model_box(input int lx, input int ly, input int lz,
                                   input int hx, input int hy, input int hz);
        logic [CFG_IDX_W-1:0] idx [6];
        int vals [6];
        idx  = '{REG_MODEL_MIN_X, REG_MODEL_MIN_Y, REG_MODEL_MIN_Z,
                 REG_MODEL_MAX_X, REG_MODEL_MAX_Y, REG_MODEL_MAX_Z};
        vals = '{lx, ly, lz, hx, hy, hz};
        for (int i = 0; i < 6; i++) begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            model_reg[idx[i]] = vals[i];
        end
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Each set starts with a first box most of the time; a missing one lets
    // the previous set grow, which also runs the store into its capacity.
    task automatic queue_random_sets(input int stored_target);
        int queued;
        int set_size;
        int span;
        queued = 0;
        while (queued < stored_target) begin
            set_size = ($urandom_range(0, 99) < 15) ? $urandom_range(31, 36)
                                                    : $urandom_range(1, 12);
            case ($urandom_range(0, 2))
                0:       span = 64;
                1:       span = 4000;
                default: span = 1 << 20;
            endcase
            for (int pos = 0; pos < set_size; pos++) begin
                queue_box(random_box((pos == 0) && ($urandom_range(0, 9) != 0), span));
                if (pos < MAX_BOXES)
                    queued++;
            end
        end
    endtask

    // Waits until every request is taken and every pair is out, then lets a
    // full scan pass, since a box without overlaps leaves no trace.
    task automatic settle();
        do
            @(negedge clk);
        while (pending_boxes.size() != 0 || in_valid || expected_pairs.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial begin
        for (int i = 0; i < 6; i++)
            model_reg[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, model box still at its reset value.
        queue_box(make_box(1, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        queue_box(make_box(0, 1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        queue_box(make_box(0, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        queue_box(make_box(0, 0, 32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff,
                           32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f));
        queue_box(make_box(0, 1, 5, 5, 5, -5, -5, -5));
        queue_box(make_box(1, 1, 0, 0, 0, 10, 10, 10));
        queue_box(make_box(0, 1, 10, 0, 0, 20, 10, 10));
        queue_box(make_box(0, 1, 21, 0, 0, 30, 10, 10));
        queue_box(make_box(0, 1, -5, 5, 5, 25, 5, 5));
        queue_box(make_box(0, 1, 0, 11, 0, 10, 12, 10));
        queue_box(make_box(0, 1, 0, 0, -10, 10, 10, -1));
        queue_box(make_box(0, 1, 0, 0, -10, 10, 10, 0));
        queue_box(make_box(1, 0, 1, 2, 3, 4, 5, 6));
        queue_box(make_box(0, 0, -7, -8, -9, 7, 8, 9));
        queue_box(make_box(0, 1, 0, 0, 0, 0, 0, 0));
        settle();

        write_model_box(-50, -50, -50, 50, 50, 50);
        queue_random_sets(25);
        settle();

        // Model box covering the whole space.
        write_model_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_random_sets(25);
        settle();

        // Fully inverted model box.
        write_model_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_random_sets(12);
        settle();

        write_model_box(int'($urandom_range(0, 2000)) - 1000, int'($urandom_range(0, 2000)) - 1000,
                        int'($urandom_range(0, 2000)) - 1000, $urandom, $urandom, $urandom);
        queue_random_sets(12);
        settle();

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
rtl/aabb_pkg.sv
rtl/aabb_ram.sv
rtl/aabb_pair_overlap_finder_top.sv
bench/tb_aabb_pair_overlap_finder_top.sv
